### rtl/core/aew_pkg.sv
// constants, register indexes and reset values of the adamw element update engine
`default_nettype none
package aew_pkg;
	localparam int unsigned RT_STAGES = 32;
	localparam int unsigned DV_STAGES = 56;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BETA_ONE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA_TWO      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EPS_OFFSET    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCHEDULE_MULT = 3'd5;

	localparam logic [31:0] RST_BETA_ONE      = 32'd3865470566;
	localparam logic [31:0] RST_BETA_TWO      = 32'd4290672329;
	localparam logic [31:0] RST_EPS_OFFSET    = 32'd1;
	localparam logic [31:0] RST_STEP_RATE     = 32'd4294967;
	localparam logic [31:0] RST_DECAY_RATE    = 32'd0;
	localparam logic [31:0] RST_SCHEDULE_MULT = 32'd2147483648;

	localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;
endpackage
`default_nettype wire

### rtl/core/adamw_element_update.sv
// top level of the adamw element update engine: moments, square root, divide, scaling
// One item per cycle while s_tready is high, fully pipelined; from acceptance to result:
// five stages for the moment updates, 32 stages of a one-bit-per-stage square root,
// two stages of products, 56 stages of a one-bit-per-stage restoring divider, four
// stages of scaling and an output register. s_tready drops only while the output
// register holds a result that is not taken and the stage before it is full.
// Registers are written through cfg_* at any time but are only to be changed while
// the pipeline is empty. A zero divisor (zero second moment and zero epsilon)
// returns a saturated update with the sign of the new first moment.
`default_nettype none
module adamw_element_update (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [143:0] s_tdata,  // gradient, weight, first_moment_in, second_moment_in
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [111:0]      m_tdata,  // first_moment_out, second_moment_out, weight_update
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [aew_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]  cfg_data
);
	localparam int unsigned RTN = aew_pkg::RT_STAGES;
	localparam int unsigned DVN = aew_pkg::DV_STAGES;

	logic [31:0] beta_one_q, beta_two_q, eps_offset_q, step_rate_q, decay_rate_q, sched_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_one_q   <= aew_pkg::RST_BETA_ONE;
			beta_two_q   <= aew_pkg::RST_BETA_TWO;
			eps_offset_q <= aew_pkg::RST_EPS_OFFSET;
			step_rate_q  <= aew_pkg::RST_STEP_RATE;
			decay_rate_q <= aew_pkg::RST_DECAY_RATE;
			sched_q      <= aew_pkg::RST_SCHEDULE_MULT;
		end else if (cfg_valid) begin
			case (cfg_index)
				aew_pkg::REG_BETA_ONE:      beta_one_q   <= cfg_data;
				aew_pkg::REG_BETA_TWO:      beta_two_q   <= cfg_data;
				aew_pkg::REG_EPS_OFFSET:    eps_offset_q <= cfg_data;
				aew_pkg::REG_STEP_RATE:     step_rate_q  <= cfg_data;
				aew_pkg::REG_DECAY_RATE:    decay_rate_q <= cfg_data;
				aew_pkg::REG_SCHEDULE_MULT: sched_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall control
	logic out_free, en, v_s11;
	assign out_free = !m_tvalid || m_tready;
	assign en       = out_free || !v_s11;
	assign s_tready = en;

	// s1: capture
	logic               v_s1;
	logic signed [31:0] g_s1, w_s1, m_s1;
	logic [47:0]        vi_s1;
	logic [31:0]        ag_s1;
	logic signed [31:0] g_in;
	assign g_in = $signed(s_tdata[31:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1  <= g_in;
			w_s1  <= $signed(s_tdata[63:32]);
			m_s1  <= $signed(s_tdata[95:64]);
			vi_s1 <= s_tdata[143:96];
			ag_s1 <= g_in[31] ? (~s_tdata[31:0] + 32'd1) : s_tdata[31:0];
		end
	end

	// s2: first products
	logic               v_s2;
	logic signed [65:0] p1_s2, p2_s2;
	logic [63:0]        sq_s2, pvl_s2;
	logic [47:0]        pvh_s2;
	logic signed [31:0] w_s2;
	logic [32:0]        c1;
	assign c1 = 33'h1_0000_0000 - {1'b0, beta_one_q};

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2  <= $signed({1'b0, beta_one_q}) * m_s1;
			p2_s2  <= $signed({1'b0, c1}) * g_s1;
			sq_s2  <= ag_s1 * ag_s1;
			pvl_s2 <= beta_two_q * vi_s1[31:0];
			pvh_s2 <= beta_two_q * vi_s1[47:32];
			w_s2   <= w_s1;
		end
	end

	// s3: first moment, gradient square
	logic               v_s3;
	logic signed [31:0] mn_s3, w_s3;
	logic [46:0]        gg_s3;
	logic [79:0]        bv_s3;
	logic signed [65:0] msum;
	logic [63:0]        gsum;
	assign msum = p1_s2 + p2_s2 + 66'sd2147483648;
	assign gsum = sq_s2 + 64'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s3 <= msum[63:32];
			gg_s3 <= gsum[62:16];
			bv_s3 <= {16'd0, pvl_s2} + {pvh_s2, 32'd0};
			w_s3  <= w_s2;
		end
	end

	// s4: gradient square products
	logic               v_s4;
	logic [64:0]        pgl_s4;
	logic [47:0]        pgh_s4;
	logic [79:0]        bv_s4;
	logic signed [31:0] mn_s4, w_s4;
	logic [32:0]        c2;
	assign c2 = 33'h1_0000_0000 - {1'b0, beta_two_q};

	always_ff @(posedge clk) begin
		if (en) begin
			pgl_s4 <= c2 * gg_s3[31:0];
			pgh_s4 <= c2 * gg_s3[46:32];
			bv_s4  <= bv_s3;
			mn_s4  <= mn_s3;
			w_s4   <= w_s3;
		end
	end

	// s5: second moment
	logic               v_s5;
	logic [47:0]        vn_s5;
	logic signed [31:0] mn_s5, w_s5;
	logic [80:0]        vsum;
	assign vsum = {1'b0, bv_s4} + {16'd0, pgl_s4} + {1'b0, pgh_s4, 32'd0} + 81'd2147483648;

	always_ff @(posedge clk) begin
		if (en) begin
			vn_s5 <= vsum[79:32];
			mn_s5 <= mn_s4;
			w_s5  <= w_s4;
		end
	end

	// square root, one result bit per stage
	logic               rt_vld_s [1:RTN];
	logic [33:0]        rt_rem_s [1:RTN];
	logic [31:0]        rt_root_s[1:RTN];
	logic [63:0]        rt_x_s   [1:RTN];
	logic [47:0]        rt_vn_s  [1:RTN];
	logic signed [31:0] rt_mn_s  [1:RTN];
	logic signed [31:0] rt_w_s   [1:RTN];

	for (genvar k = 1; k <= RTN; k++) begin : g_rt
		logic               pv;
		logic [33:0]        prem;
		logic [31:0]        proot;
		logic [63:0]        px;
		logic [47:0]        pvn;
		logic signed [31:0] pmn, pw;
		logic [35:0]        r2, tr;
		if (k == 1) begin : g_first
			assign pv    = v_s5;
			assign prem  = '0;
			assign proot = '0;
			assign px    = {vn_s5, 16'd0};
			assign pvn   = vn_s5;
			assign pmn   = mn_s5;
			assign pw    = w_s5;
		end else begin : g_next
			assign pv    = rt_vld_s[k-1];
			assign prem  = rt_rem_s[k-1];
			assign proot = rt_root_s[k-1];
			assign px    = rt_x_s[k-1];
			assign pvn   = rt_vn_s[k-1];
			assign pmn   = rt_mn_s[k-1];
			assign pw    = rt_w_s[k-1];
		end
		assign r2 = {prem, px[63:62]};
		assign tr = {2'b00, proot, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else if (en) begin
				rt_vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (r2 >= tr) begin
					rt_rem_s[k]  <= 34'(r2 - tr);
					rt_root_s[k] <= {proot[30:0], 1'b1};
				end else begin
					rt_rem_s[k]  <= r2[33:0];
					rt_root_s[k] <= {proot[30:0], 1'b0};
				end
				rt_x_s[k]  <= {px[61:0], 2'b00};
				rt_vn_s[k] <= pvn;
				rt_mn_s[k] <= pmn;
				rt_w_s[k]  <= pw;
			end
		end
	end

	// s6: divisor, numerator and decay products
	logic               v_s6;
	logic [32:0]        dv_s6;
	logic [63:0]        pn_s6, pw_s6;
	logic signed [31:0] mn_s6;
	logic [47:0]        vn_s6;
	logic               wneg_s6;
	logic [31:0]        am, aw;
	logic signed [31:0] mn_rt, w_rt;
	assign mn_rt = rt_mn_s[RTN];
	assign w_rt  = rt_w_s[RTN];
	assign am = mn_rt[31] ? (~mn_rt + 32'd1) : mn_rt;
	assign aw = w_rt[31] ? (~w_rt + 32'd1) : w_rt;

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s6   <= {1'b0, rt_root_s[RTN]} + {1'b0, eps_offset_q};
			pn_s6   <= am * step_rate_q;
			pw_s6   <= aw * decay_rate_q;
			mn_s6   <= mn_rt;
			vn_s6   <= rt_vn_s[RTN];
			wneg_s6 <= w_rt[31];
		end
	end

	// s7: dividend, divisor, decay term
	logic               v_s7;
	logic [63:0]        num_s7;
	logic [40:0]        den_s7;
	logic               dz_s7, wneg_s7;
	logic [31:0]        dt_s7;
	logic signed [31:0] mn_s7;
	logic [47:0]        vn_s7;
	logic [63:0]        dsum;
	assign dsum = pw_s6 + 64'd2147483648;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s7  <= pn_s6 + {24'd0, dv_s6, 7'd0};
			den_s7  <= {dv_s6, 8'd0};
			dz_s7   <= (dv_s6 == 33'd0);
			dt_s7   <= dsum[63:32];
			mn_s7   <= mn_s6;
			vn_s7   <= vn_s6;
			wneg_s7 <= wneg_s6;
		end
	end

	// restoring divider, one quotient bit per stage
	logic               dv_vld_s [1:DVN];
	logic [40:0]        dv_rem_s [1:DVN];
	logic [DVN-1:0]     dv_q_s   [1:DVN];
	logic [DVN-1:0]     dv_n_s   [1:DVN];
	logic [40:0]        dv_den_s [1:DVN];
	logic [31:0]        dv_dt_s  [1:DVN];
	logic signed [31:0] dv_mn_s  [1:DVN];
	logic [47:0]        dv_vn_s  [1:DVN];
	logic               dv_dz_s  [1:DVN];
	logic               dv_wneg_s[1:DVN];

	for (genvar j = 1; j <= DVN; j++) begin : g_dv
		logic               pv, pdz, pwn;
		logic [40:0]        prem, pden;
		logic [DVN-1:0]     pq, pn;
		logic [31:0]        pdt;
		logic signed [31:0] pmn;
		logic [47:0]        pvn;
		logic [41:0]        r;
		if (j == 1) begin : g_first
			assign pv   = v_s7;
			assign prem = {33'd0, num_s7[63:DVN]};
			assign pq   = '0;
			assign pn   = num_s7[DVN-1:0];
			assign pden = den_s7;
			assign pdt  = dt_s7;
			assign pmn  = mn_s7;
			assign pvn  = vn_s7;
			assign pdz  = dz_s7;
			assign pwn  = wneg_s7;
		end else begin : g_next
			assign pv   = dv_vld_s[j-1];
			assign prem = dv_rem_s[j-1];
			assign pq   = dv_q_s[j-1];
			assign pn   = dv_n_s[j-1];
			assign pden = dv_den_s[j-1];
			assign pdt  = dv_dt_s[j-1];
			assign pmn  = dv_mn_s[j-1];
			assign pvn  = dv_vn_s[j-1];
			assign pdz  = dv_dz_s[j-1];
			assign pwn  = dv_wneg_s[j-1];
		end
		assign r = {prem, pn[DVN-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j] <= 1'b0;
			end else if (en) begin
				dv_vld_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (r >= {1'b0, pden}) begin
					dv_rem_s[j] <= 41'(r - {1'b0, pden});
					dv_q_s[j]   <= {pq[DVN-2:0], 1'b1};
				end else begin
					dv_rem_s[j] <= r[40:0];
					dv_q_s[j]   <= {pq[DVN-2:0], 1'b0};
				end
				dv_n_s[j]    <= {pn[DVN-2:0], 1'b0};
				dv_den_s[j]  <= pden;
				dv_dt_s[j]   <= pdt;
				dv_mn_s[j]   <= pmn;
				dv_vn_s[j]   <= pvn;
				dv_dz_s[j]   <= pdz;
				dv_wneg_s[j] <= pwn;
			end
		end
	end

	// s8: signed sum of both terms
	logic               v_s8, dz_s8;
	logic signed [57:0] t_s8;
	logic signed [31:0] mn_s8;
	logic [47:0]        vn_s8;
	logic signed [57:0] qs, ds;
	logic signed [31:0] mn_dv;
	assign mn_dv = dv_mn_s[DVN];
	assign qs = mn_dv[31] ? -$signed({2'b00, dv_q_s[DVN]}) : $signed({2'b00, dv_q_s[DVN]});
	assign ds = dv_wneg_s[DVN] ? -$signed({26'd0, dv_dt_s[DVN]})
	                           : $signed({26'd0, dv_dt_s[DVN]});

	always_ff @(posedge clk) begin
		if (en) begin
			t_s8  <= qs + ds;
			dz_s8 <= dv_dz_s[DVN];
			mn_s8 <= mn_dv;
			vn_s8 <= dv_vn_s[DVN];
		end
	end

	// s9: magnitude
	logic               v_s9, dz_s9, tneg_s9;
	logic [56:0]        at_s9;
	logic signed [31:0] mn_s9;
	logic [47:0]        vn_s9;
	logic [57:0]        tneg_v;
	assign tneg_v = 58'(-t_s8);

	always_ff @(posedge clk) begin
		if (en) begin
			tneg_s9 <= t_s8[57];
			at_s9   <= t_s8[57] ? tneg_v[56:0] : t_s8[56:0];
			dz_s9   <= dz_s8;
			mn_s9   <= mn_s8;
			vn_s9   <= vn_s8;
		end
	end

	// s10: schedule products
	logic               v_s10, dz_s10, tneg_s10;
	logic [63:0]        pl_s10;
	logic [56:0]        ph_s10;
	logic signed [31:0] mn_s10;
	logic [47:0]        vn_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s10   <= at_s9[31:0] * sched_q;
			ph_s10   <= at_s9[56:32] * sched_q;
			tneg_s10 <= tneg_s9;
			dz_s10   <= dz_s9;
			mn_s10   <= mn_s9;
			vn_s10   <= vn_s9;
		end
	end

	// s11: rounded magnitude
	logic               dz_s11, tneg_s11;
	logic [58:0]        mag_s11;
	logic signed [31:0] mn_s11;
	logic [47:0]        vn_s11;
	logic [89:0]        psum;
	assign psum = {26'd0, pl_s10} + {1'b0, ph_s10, 32'd0} + 90'd1073741824;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s11  <= psum[89:31];
			tneg_s11 <= tneg_s10;
			dz_s11   <= dz_s10;
			mn_s11   <= mn_s10;
			vn_s11   <= vn_s10;
		end
	end

	// saturation
	logic [31:0] upd;
	always_comb begin
		if (dz_s11) begin
			upd = mn_s11[31] ? aew_pkg::SAT_NEG : aew_pkg::SAT_POS;
		end else if (tneg_s11) begin
			upd = (mag_s11 > 59'd2147483648) ? aew_pkg::SAT_NEG : (~mag_s11[31:0] + 32'd1);
		end else begin
			upd = (mag_s11 > 59'd2147483647) ? aew_pkg::SAT_POS : mag_s11[31:0];
		end
	end

	// valid bits of the named stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= rt_vld_s[RTN];
			v_s7  <= v_s6;
			v_s8  <= dv_vld_s[DVN];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// output register
	logic [111:0] out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s11) begin
			out_q <= {upd, vn_s11, mn_s11};
		end
	end

	assign m_tdata = out_q;

	a_stall_only_at_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && v_s11))
		else $error("input stalled without a held result");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s11 && out_free) |=> m_tvalid)
		else $error("finished item not moved to output");

	a_zero_divisor_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s11 && out_free && dz_s11) |=>
		(m_tdata[111:80] == aew_pkg::SAT_POS || m_tdata[111:80] == aew_pkg::SAT_NEG))
		else $error("zero divisor without saturated update");
endmodule
`default_nettype wire

### verif/adamw_element_update_check.sv
// checker for the adamw element update engine: predicts every result and compares it
`timescale 1ns / 100ps
`default_nettype none
module adamw_element_update_check (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [143:0] s_tdata,  // gradient, weight, first_moment_in, second_moment_in
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [111:0] m_tdata,  // first_moment_out, second_moment_out, weight_update
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [aew_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]  cfg_data,
	output int                fail_count,
	output int                outstanding
);
	typedef struct packed {
		logic [31:0] first_moment;
		logic [47:0] second_moment;
		logic [31:0] update;
	} moment_result_t;

	logic [31:0] beta_one, beta_two, eps_offset, step_rate, decay_rate, schedule_mult;
	moment_result_t expected_results[$];

	function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic moment_result_t predict_element_update(input logic [143:0] item);
		moment_result_t res;
		logic signed [71:0] g, w, m, b1, mix, mn;
		logic [127:0] ag, gg, vsum, vn, dv, am, q, aw, dt, at, prod, mag;
		logic signed [71:0] t;
		g = {{40{item[31]}}, item[31:0]};
		w = {{40{item[63]}}, item[63:32]};
		m = {{40{item[95]}}, item[95:64]};
		b1 = {40'd0, beta_one};
		mix = b1 * m + ((72'sd1 <<< 32) - b1) * g + (72'sd1 <<< 31);
		mn = mix >>> 32;
		ag = g < 0 ? -g : g;
		gg = (ag * ag + 128'd32768) >> 16;
		vsum = beta_two * {80'd0, item[143:96]} + ((128'd1 << 32) - beta_two) * gg
			+ (128'd1 << 31);
		vn = (vsum >> 32) & 128'hffff_ffff_ffff;
		dv = sqrt_floor(vn[47:0] << 16) + eps_offset;
		if (dv == 0) begin
			res.update = mn < 0 ? aew_pkg::SAT_NEG : aew_pkg::SAT_POS;
		end else begin
			am = mn < 0 ? -mn : mn;
			q = (am * step_rate + (dv << 7)) / (dv << 8);
			aw = w < 0 ? -w : w;
			dt = (aw * decay_rate + (128'd1 << 31)) >> 32;
			t = (mn < 0 ? -$signed({1'b0, q[70:0]}) : $signed({1'b0, q[70:0]}))
				+ (w < 0 ? -$signed({1'b0, dt[70:0]}) : $signed({1'b0, dt[70:0]}));
			at = t < 0 ? -t : t;
			prod = at * schedule_mult + (128'd1 << 30);
			mag = prod >> 31;
			if (t < 0)
				res.update = mag > 128'h8000_0000 ? aew_pkg::SAT_NEG : -mag[31:0];
			else
				res.update = mag > 128'h7fff_ffff ? aew_pkg::SAT_POS : mag[31:0];
		end
		res.first_moment = mn[31:0];
		res.second_moment = vn[47:0];
		return res;
	endfunction

	assign outstanding = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		moment_result_t exp_r;
		moment_result_t got;
		if (!arst_n) begin
			beta_one <= aew_pkg::RST_BETA_ONE;
			beta_two <= aew_pkg::RST_BETA_TWO;
			eps_offset <= aew_pkg::RST_EPS_OFFSET;
			step_rate <= aew_pkg::RST_STEP_RATE;
			decay_rate <= aew_pkg::RST_DECAY_RATE;
			schedule_mult <= aew_pkg::RST_SCHEDULE_MULT;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					aew_pkg::REG_BETA_ONE: beta_one <= cfg_data;
					aew_pkg::REG_BETA_TWO: beta_two <= cfg_data;
					aew_pkg::REG_EPS_OFFSET: eps_offset <= cfg_data;
					aew_pkg::REG_STEP_RATE: step_rate <= cfg_data;
					aew_pkg::REG_DECAY_RATE: decay_rate <= cfg_data;
					aew_pkg::REG_SCHEDULE_MULT: schedule_mult <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_results = {expected_results, predict_element_update(s_tdata)};
			if (m_tvalid && m_tready) begin
				got.first_moment = m_tdata[31:0];
				got.second_moment = m_tdata[79:32];
				got.update = m_tdata[111:80];
				if (expected_results.size() == 0) begin
					$error("result item with no expectation: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got != exp_r)
						fail_count <= fail_count + 1;
					if (got.first_moment != exp_r.first_moment)
						$error("first_moment_out expected %h got %h",
							exp_r.first_moment, got.first_moment);
					if (got.second_moment != exp_r.second_moment)
						$error("second_moment_out expected %h got %h",
							exp_r.second_moment, got.second_moment);
					if (got.update != exp_r.update)
						$error("weight_update expected %h got %h",
							exp_r.update, got.update);
				end
			end
		end
	end
endmodule
`default_nettype wire

### verif/adamw_element_update_test.sv
// top of the adamw element update testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none
module adamw_element_update_test;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 120;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [143:0] s_tdata = 0;  // gradient, weight, first_moment_in, second_moment_in
	logic m_tvalid;
	logic m_tready = 0;
	logic [111:0] m_tdata;  // first_moment_out, second_moment_out, weight_update
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [aew_pkg::CFG_IDX_W-1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	int fail_count;
	int outstanding;
	bit quiet = 0;
	int stall_cycles = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	adamw_element_update i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	adamw_element_update_check i_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .outstanding(outstanding)
	);

	// receiver stalls in random bursts
	int hold = 0;
	always @(posedge clk) begin
		logic rdy;
		rdy = 1;
		if (hold > 0) begin
			hold = hold - 1;
			rdy = 0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			hold = $urandom_range(1, 11) - 1;
			rdy = 0;
		end
		m_tready <= rdy;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_element(input logic [31:0] g, input logic [31:0] w,
		input logic [31:0] m, input logic [47:0] v);
		bit ok;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {v, m, w, g};
		ok = 0;
		while (!ok) begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end
	endtask

	task automatic drain_pipeline;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [aew_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] val);
		bit ok;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		ok = 0;
		while (!ok) begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_coeff(input logic [31:0] hi);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return hi;
			2: return $urandom_range(0, 255);
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	task automatic load_settings(input logic [31:0] b1, input logic [31:0] b2,
		input logic [31:0] eps, input logic [31:0] rate, input logic [31:0] dec,
		input logic [31:0] yita);
		s_tvalid <= 0;
		drain_pipeline();
		write_reg(aew_pkg::REG_BETA_ONE, b1);
		write_reg(aew_pkg::REG_BETA_TWO, b2);
		write_reg(aew_pkg::REG_EPS_OFFSET, eps);
		write_reg(aew_pkg::REG_STEP_RATE, rate);
		write_reg(aew_pkg::REG_DECAY_RATE, dec);
		write_reg(aew_pkg::REG_SCHEDULE_MULT, yita);
		cfg_valid <= 0;
	endtask

	task automatic send_random_element;
		logic [31:0] g, w, m;
		logic [47:0] v;
		g = $urandom;
		w = $urandom;
		m = $urandom;
		v = {16'($urandom_range(0, 65535)), $urandom};
		case ($urandom_range(0, 5))
			0: begin
				g = $urandom_range(0, 362) - 181;
				v = 0;
			end
			1: begin
				g = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
				m = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
				v = 48'($urandom_range(0, 1 << 30));
			end
			2: v = v >> $urandom_range(0, 47);
			default: ;
		endcase
		send_element(g, w, m, v);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_element(0, 0, 0, 0);
		send_element(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 48'hffff_ffff_ffff);
		send_element(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_element(32'hffff_ffff, 1, 32'hffff_ffff, 1);
		send_element(32'h0100_0000, 32'hff00_0000, 32'h0080_0000, 48'h1_0000_0000);
		send_element(32'hff00_0000, 32'h0100_0000, 32'hff80_0000, 48'h0000_0001_0000);

		// zero divisor with either sign of the first moment
		load_settings(aew_pkg::RST_BETA_ONE, aew_pkg::RST_BETA_TWO, 0, 32'hffff_ffff,
			32'hffff_ffff, 32'h8000_0000);
		send_element(0, 32'h7fff_ffff, 0, 0);
		send_element(32'hffff_ff9c, 32'h8000_0000, 32'h8000_0000, 0);
		send_element(181, 5, 32'h7fff_ffff, 0);
		send_element(32'hffff_ff4b, 0, 1, 0);
		send_element(182, 0, 0, 0);

		// extreme coefficients
		load_settings(0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
		send_element(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 48'hffff_ffff_ffff);
		send_element(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		load_settings(32'hffff_ffff, 32'hffff_ffff, 0, 32'hffff_ffff, 32'hffff_ffff,
			32'h8000_0000);
		send_element(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 48'hffff_ffff_ffff);
		send_element(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
		send_element(1, 32'h8000_0000, 1, 48'h0000_0000_0100);
		s_tvalid <= 0;
		drain_pipeline();
		write_reg(3'd6, $urandom);
		write_reg(3'd7, $urandom);
		cfg_valid <= 0;
		send_element(32'h7fff_ffff, 32'h7fff_ffff, 32'h4000_0000, 0);

		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 0)
				load_settings(aew_pkg::RST_BETA_ONE, aew_pkg::RST_BETA_TWO,
					aew_pkg::RST_EPS_OFFSET, aew_pkg::RST_STEP_RATE,
					aew_pkg::RST_DECAY_RATE, aew_pkg::RST_SCHEDULE_MULT);
			else
				load_settings(pick_coeff(32'hffff_ffff), pick_coeff(32'hffff_ffff),
					pick_coeff(32'hffff_ffff), pick_coeff(32'hffff_ffff),
					pick_coeff(32'hffff_ffff), pick_coeff(32'h8000_0000));
			if (phase == 9)
				quiet = 1;
			for (int k = 0; k < 85; k++) begin
				if (phase == 4 && k == 40) begin
					s_tvalid <= 0;
					while (outstanding != 0)
						@(posedge clk);
				end
				send_random_element();
			end
		end
		s_tvalid <= 0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
rtl/core/aew_pkg.sv
rtl/core/adamw_element_update.sv
verif/adamw_element_update_check.sv
verif/adamw_element_update_test.sv
